// ----- hw/rtl/uer_pkg.sv -----
// ============================================================================
// uer_pkg
// Shared types and constants for the ultrasonic echo ranger.
// ============================================================================
package uer_pkg;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 24;
   localparam int DIST_W     = 16;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_MEASURE_PERIOD = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_TRIGGER_WIDTH  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_TICKS_PER_CM   = 2'd2;

   localparam logic [23:0] MEASURE_PERIOD_RST = 24'd200000;
   localparam logic [7:0]  TRIGGER_WIDTH_RST  = 8'd20;
   localparam logic [15:0] TICKS_PER_CM_RST   = 16'd116;

   localparam logic [7:0]  SPACE_BYTE = 8'h20;

   // report beat within one tick
   localparam logic [1:0] BEAT_HI  = 2'd0;
   localparam logic [1:0] BEAT_LO  = 2'd1;
   localparam logic [1:0] BEAT_TAG = 2'd2;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_TRIGGER = 2'd1,
      PH_WAIT    = 2'd2,
      PH_DONE    = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_DIV  = 2'd1,
      S_OUT  = 2'd2
   } ctl_state_type;

   typedef struct packed {
      logic trig;
      logic report;
   } meas_out_type;

endpackage

// ----- hw/rtl/uer_divider.sv -----
// ============================================================================
// uer_divider
// Restoring divider, one quotient bit per cycle; zero divisor gives all ones.
// ============================================================================
module uer_divider #(
   parameter int W = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [15:0]  divisor,
   output logic         done,
   output logic [W-1:0] quotient
);

   localparam int CW = $clog2(W + 1);

   logic [15:0]   rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [16:0]   trial;
   logic [16:0]   diff;
   logic          ge;

   // quo_ff shifts the dividend out at the top and the quotient in below
   assign trial = {rem_ff, quo_ff[W-1]};
   assign ge    = trial >= {1'b0, divisor};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[15:0] : trial[15:0];
         quo_in = {quo_ff[W-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- hw/rtl/uer_meas.sv -----
// ============================================================================
// uer_meas
// Per-tick measurement state: period restart, trigger pulse, echo captures.
// ============================================================================
module uer_meas #(
   parameter int TIMER_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  echo,
   input  logic [23:0]           measure_period,
   input  logic [7:0]            trigger_width,
   output uer_pkg::meas_out_type meas,
   output logic [TIMER_BITS-1:0] diff
);

   uer_pkg::phase_type    phase_ff, phase_in, ph;
   logic [23:0]           period_ff, period_in, period_inc;
   logic [7:0]            tcount_ff, tcount_in, tcount_inc;
   logic [TIMER_BITS-1:0] timer_ff, start_ff, start_in, stop_ff, stop_in;
   logic                  prev_ff, rise_ff, rise_in, pend_ff, pend_in, pend;
   logic                  restart;

   assign period_inc = period_ff + 24'd1;
   assign restart    = period_inc >= measure_period;
   assign tcount_inc = tcount_ff + 8'd1;
   assign diff       = stop_ff - start_ff;

   always_comb begin
      period_in = restart ? '0 : period_inc;
      pend      = restart | pend_ff;
      ph        = restart ? uer_pkg::PH_IDLE : phase_ff;
      phase_in  = ph;
      pend_in   = pend;
      tcount_in = tcount_ff;
      rise_in   = rise_ff;
      start_in  = start_ff;
      stop_in   = stop_ff;
      meas      = '0;
      case (ph)
         uer_pkg::PH_IDLE: begin
            if (pend) begin
               phase_in  = uer_pkg::PH_TRIGGER;
               tcount_in = '0;
            end
         end
         uer_pkg::PH_TRIGGER: begin
            meas.trig = 1'b1;
            pend_in   = 1'b0;
            tcount_in = tcount_inc;
            if (tcount_inc >= trigger_width) begin
               phase_in = uer_pkg::PH_WAIT;
               rise_in  = 1'b0;
            end
         end
         uer_pkg::PH_WAIT: begin
            if (echo && !prev_ff && !rise_ff) begin
               start_in = timer_ff;
               rise_in  = 1'b1;
            end else if (!echo && prev_ff && rise_ff) begin
               stop_in  = timer_ff;
               phase_in = uer_pkg::PH_DONE;
            end
         end
         default: begin
            meas.report = 1'b1;
            phase_in    = uer_pkg::PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= uer_pkg::PH_IDLE;
         period_ff <= '0;
         tcount_ff <= '0;
         timer_ff  <= '0;
         start_ff  <= '0;
         stop_ff   <= '0;
         prev_ff   <= 1'b0;
         rise_ff   <= 1'b0;
         pend_ff   <= 1'b1;
      end else if (step) begin
         phase_ff  <= phase_in;
         period_ff <= period_in;
         tcount_ff <= tcount_in;
         timer_ff  <= timer_ff + TIMER_BITS'(1);
         start_ff  <= start_in;
         stop_ff   <= stop_in;
         prev_ff   <= echo;
         rise_ff   <= rise_in;
         pend_ff   <= pend_in;
      end
   end

endmodule

// ----- hw/rtl/ultrasonic_echo_ranger.sv -----
// A plain tick gives its result in the cycle after the request is taken.
// A reporting tick runs the divider (one quotient bit a cycle); its first
// result comes once the divider is done and the distance is registered,
// and the other two follow as the results before them are taken.
// No new request is taken until the last result of a tick is taken,
// as set by the single shared divider and the one-request-at-a-time sequencer.
// Reset (synchronous): state and configuration registers to their defaults, first measurement pending.
// ============================================================================
// ultrasonic_echo_ranger
// Echo ranging controller: trigger pulse, echo timing, distance report bytes.
// ============================================================================
module ultrasonic_echo_ranger #(
   parameter int TIMER_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [0] echo_level
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [15:0]                    rsp_tdata,   // [0] trigger_level, [8:1] data_byte
   output logic                           rsp_tuser,   // [0] byte_valid
   output logic                           rsp_tlast,
   input  logic                           csr_we,
   input  logic [uer_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [uer_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic [23:0] measure_period_ff;
   logic [7:0]  trigger_width_ff;
   logic [15:0] ticks_per_cm_ff;

   uer_pkg::ctl_state_type state_ff, state_in;
   logic [1:0]             beat_ff, beat_in;
   logic                   rep_ff, rep_in, trig_ff, trig_in;
   logic [15:0]            dist_ff, dist_in, div_dist;
   logic                   step, div_start, div_done;
   logic [7:0]             data_byte;
   uer_pkg::meas_out_type  meas;
   logic [TIMER_BITS-1:0]  meas_diff, quotient;

   assign step = req_tvalid & req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         measure_period_ff <= uer_pkg::MEASURE_PERIOD_RST;
         trigger_width_ff  <= uer_pkg::TRIGGER_WIDTH_RST;
         ticks_per_cm_ff   <= uer_pkg::TICKS_PER_CM_RST;
      end else if (csr_we) begin
         case (csr_addr)
            uer_pkg::CSR_MEASURE_PERIOD: measure_period_ff <= csr_wdata;
            uer_pkg::CSR_TRIGGER_WIDTH:  trigger_width_ff  <= csr_wdata[7:0];
            uer_pkg::CSR_TICKS_PER_CM:   ticks_per_cm_ff   <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   uer_meas #(.TIMER_BITS(TIMER_BITS)) u_meas (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .echo           (req_tdata[0]),
      .measure_period (measure_period_ff),
      .trigger_width  (trigger_width_ff),
      .meas           (meas),
      .diff           (meas_diff)
   );

   uer_divider #(.W(TIMER_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (meas_diff),
      .divisor  (ticks_per_cm_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // clamp the quotient to 16 bits
   generate
      if (TIMER_BITS > 16) begin : g_sat
         assign div_dist = (|quotient[TIMER_BITS-1:16]) ? 16'hFFFF : quotient[15:0];
      end else if (TIMER_BITS == 16) begin : g_eq
         assign div_dist = quotient;
      end else begin : g_ext
         // a zero divisor still saturates to the full 16 bits
         assign div_dist = (ticks_per_cm_ff == 16'd0) ? 16'hFFFF
                                                      : {{(16 - TIMER_BITS){1'b0}}, quotient};
      end
   endgenerate

   always_comb begin
      state_in   = state_ff;
      beat_in    = beat_ff;
      rep_in     = rep_ff;
      trig_in    = trig_ff;
      dist_in    = dist_ff;
      div_start  = 1'b0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         uer_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               trig_in = meas.trig;
               rep_in  = meas.report;
               if (meas.report) begin
                  div_start = 1'b1;
                  beat_in   = uer_pkg::BEAT_HI;
                  state_in  = uer_pkg::S_DIV;
               end else begin
                  beat_in  = uer_pkg::BEAT_TAG;
                  state_in = uer_pkg::S_OUT;
               end
            end
         end
         uer_pkg::S_DIV: begin
            if (div_done) begin
               dist_in  = div_dist;
               state_in = uer_pkg::S_OUT;
            end
         end
         uer_pkg::S_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (beat_ff == uer_pkg::BEAT_TAG) begin
                  state_in = uer_pkg::S_IDLE;
               end else begin
                  beat_in = beat_ff + 2'd1;
               end
            end
         end
         default: begin
            state_in = uer_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= uer_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      beat_ff <= beat_in;
      rep_ff  <= rep_in;
      trig_ff <= trig_in;
      dist_ff <= dist_in;
   end

   always_comb begin
      case (beat_ff)
         uer_pkg::BEAT_HI: data_byte = dist_ff[15:8];
         uer_pkg::BEAT_LO: data_byte = dist_ff[7:0];
         default:          data_byte = rep_ff ? uer_pkg::SPACE_BYTE : 8'd0;
      endcase
   end

   assign rsp_tdata = {7'd0, data_byte, trig_ff};
   assign rsp_tuser = rep_ff;
   assign rsp_tlast = (beat_ff == uer_pkg::BEAT_TAG);

   a_no_req_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while a result is pending");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == uer_pkg::S_DIV))
      else $error("divider finished outside the divide state");

   a_plain_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> rsp_tlast)
      else $error("plain tick gave more than one result");

   a_report_divides: assert property (@(posedge clock) disable iff (reset)
      (step && meas.report) |=> (state_ff == uer_pkg::S_DIV))
      else $error("report tick did not start the divider");

endmodule
